// ----- rtl/core/postfix_expression_evaluator_assert.svh -----
// Assertion macros for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PEE_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PEE_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ----- rtl/core/pee_pkg.sv -----
// Package: types and constants of the postfix expression evaluator.
`timescale 1ns / 1ps
package pee_pkg;
	localparam int STACK_DEPTH = 128;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam logic [7:0] LIMIT_RESET = 8'd100;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef struct packed {
		logic [7:0] char_code;
		logic last;
	} pee_in_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic [7:0] final_depth;
		logic underflow_seen;
		logic overflow_seen;
		logic divide_by_zero_seen;
	} pee_out_t;

	// Divider request
	typedef struct packed {
		logic start;
		logic [31:0] num;
		logic [31:0] den;
	} pee_div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] quo;
	} pee_div_rsp_t;
endpackage

// ----- rtl/core/pee_stack_ram.sv -----
// Stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pee_stack_ram import pee_pkg::*; (
	input logic clk,
	input logic we,
	input logic [ADDR_W-1:0] waddr,
	input logic [31:0] wdata,
	input logic [ADDR_W-1:0] raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/pee_divider.sv -----
// Radix-2 restoring signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pee_divider import pee_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pee_div_req_t req,
	output pee_div_rsp_t rsp
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q, quo_q, den_q;
	logic neg_q;
	logic [32:0] trial;
	logic [31:0] na, da;

	assign na = req.num[31] ? (32'd0 - req.num) : req.num;
	assign da = req.den[31] ? (32'd0 - req.den) : req.den;
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					rsp.done <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= na;
			den_q <= da;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.quo = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

// ----- rtl/core/postfix_expression_evaluator.sv -----
// Top level: postfix evaluator with memory stack and sequencer.
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | pee_in_t
//  out     | output    | out_valid/stall  | pee_out_t
//  cfg     | input     | cfg_we           | stack_limit
// Digit, space and skipped characters are taken in IDLE; + - * go through accept, two stack reads and push.
// Division waits in ST_DIV for the radix-2 divider before the push; a zero operand skips it and pushes zero.
// The last character then passes through ST_TOP, which reads the top, and ST_FIN, which loads the result.
// Reset clears control state; stack memory is not cleared.
// A waiting result does not block new input; only a second result waits.
`timescale 1ns / 1ps
module postfix_expression_evaluator import pee_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input pee_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output pee_out_t out_data,
	input logic cfg_we,
	input logic [7:0] cfg_wdata
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1 = 3'd1;
	localparam logic [2:0] ST_RD2 = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;
	localparam logic [2:0] ST_TOP = 3'd6;

	logic [2:0] state_q;
	logic [7:0] limit_q, op_q;
	logic last_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [31:0] acc_q, first_q, res_q;
	logic pend_q, fu_q, fo_q, fz_q;
	logic [DEPTH_W-1:0] cap;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata, rd_val;
	logic accept, is_dig, is_op;
	pee_div_req_t dreq;
	pee_div_rsp_t drsp;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign is_dig = in_data.char_code >= CH_ZERO && in_data.char_code <= CH_NINE;
	assign is_op = in_data.char_code == CH_PLUS || in_data.char_code == CH_MINUS ||
		in_data.char_code == CH_STAR || in_data.char_code == CH_SLASH;
	assign cap = (limit_q < STACK_DEPTH) ? limit_q[DEPTH_W-1:0] : DEPTH_W'(STACK_DEPTH);
	// Empty stack reads as minus one
	assign rd_val = (depth_q == '0) ? 32'hFFFF_FFFF : ram_rdata;
	// Second operand sits one below the first popped entry
	assign ram_raddr = (state_q == ST_RD1) ? ADDR_W'(depth_q - DEPTH_W'(2)) :
		ADDR_W'(depth_q - DEPTH_W'(1));

	// Stack write: push of a number or an operator result
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = depth_q[ADDR_W-1:0];
		ram_wdata = acc_q;
		if (state_q == ST_IDLE && accept && in_data.char_code == CH_SPACE && pend_q &&
				depth_q < cap)
			ram_we = 1'b1;
		if (state_q == ST_PUSH && depth_q < cap) begin
			ram_we = 1'b1;
			ram_wdata = res_q;
		end
	end

	assign dreq.start = (state_q == ST_RD2) && (op_q == CH_SLASH) && (rd_val != 32'd0) &&
		(first_q != 32'd0);
	assign dreq.num = rd_val;
	assign dreq.den = first_q;

	pee_stack_ram u_ram (.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata));
	pee_divider u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= LIMIT_RESET;
			depth_q <= '0;
			acc_q <= '0;
			pend_q <= 1'b0;
			fu_q <= 1'b0;
			fo_q <= 1'b0;
			fz_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
			last_q <= 1'b0;
			op_q <= '0;
			first_q <= '0;
			res_q <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (out_valid && !out_stall && state_q != ST_FIN) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= in_data.last;
						op_q <= in_data.char_code;
						if (is_dig) begin
							acc_q <= acc_q * 32'd10 + 32'(in_data.char_code - CH_ZERO);
							pend_q <= 1'b1;
						end else if (in_data.char_code == CH_SPACE && pend_q) begin
							if (depth_q < cap) depth_q <= depth_q + DEPTH_W'(1);
							else fo_q <= 1'b1;
							acc_q <= '0;
							pend_q <= 1'b0;
						end
						if (is_op) state_q <= ST_RD1;
						else if (in_data.last) state_q <= ST_TOP;
					end
				end
				ST_RD1: begin
					first_q <= rd_val;
					if (depth_q == '0) fu_q <= 1'b1;
					else depth_q <= depth_q - DEPTH_W'(1);
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (depth_q == '0) fu_q <= 1'b1;
					else depth_q <= depth_q - DEPTH_W'(1);
					state_q <= ST_PUSH;
					case (op_q)
						CH_PLUS: res_q <= rd_val + first_q;
						CH_MINUS: res_q <= rd_val - first_q;
						CH_STAR: res_q <= rd_val * first_q;
						default: begin
							res_q <= '0;
							if (first_q == 32'd0) fz_q <= 1'b1;
							else if (rd_val != 32'd0) state_q <= ST_DIV;
						end
					endcase
				end
				ST_DIV: begin
					if (drsp.done) begin
						res_q <= drsp.quo;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (depth_q < cap) depth_q <= depth_q + DEPTH_W'(1);
					else fo_q <= 1'b1;
					state_q <= last_q ? ST_TOP : ST_IDLE;
				end
				// Wait for the top entry to come out of the registered memory read
				ST_TOP: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_data.answer <= rd_val;
						out_data.final_depth <= 8'(depth_q);
						out_data.underflow_seen <= fu_q || depth_q == '0;
						out_data.overflow_seen <= fo_q;
						out_data.divide_by_zero_seen <= fz_q;
						depth_q <= '0;
						acc_q <= '0;
						pend_q <= 1'b0;
						fu_q <= 1'b0;
						fo_q <= 1'b0;
						fz_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "postfix_expression_evaluator_assert.svh"
	`PEE_ASSERT_IMP(a_depth_cap, clk, arst_n, 1'b1, depth_q <= DEPTH_W'(STACK_DEPTH),
		"stack depth beyond memory")
	`PEE_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !accept,
		"item accepted while sequencer busy")
	`PEE_ASSERT_NXT(a_div_enter, clk, arst_n, dreq.start, state_q == ST_DIV,
		"divider started without divide state")
endmodule

// ----- tb/postfix_expression_evaluator_test.sv -----
// Testbench: scoreboarded random and directed checks of the postfix evaluator.
`timescale 1ns / 1ps
module postfix_expression_evaluator_test;
	import pee_pkg::*;

	// Expected-answer store and character-level predictor
	class rpn_scoreboard;
		logic [31:0] stk [STACK_DEPTH];
		int depth;
		logic [31:0] acc;
		bit pending, f_under, f_over, f_div0;
		logic [7:0] limit;
		pee_out_t answers_due [$];
		int mismatches;
		int checked;

		function new();
			limit = LIMIT_RESET;
			clear();
		endfunction

		function void clear();
			depth = 0; acc = 0; pending = 0;
			f_under = 0; f_over = 0; f_div0 = 0;
		endfunction

		function logic [31:0] top_val();
			if (depth == 0) begin
				f_under = 1;
				return 32'hFFFF_FFFF;
			end
			return stk[depth-1];
		endfunction

		function void pop_one();
			if (depth == 0) f_under = 1;
			else depth--;
		endfunction

		function void push_val(logic [31:0] v);
			int cap;
			cap = (limit < STACK_DEPTH) ? limit : STACK_DEPTH;
			if (depth >= cap) f_over = 1;
			else begin
				stk[depth] = v;
				depth++;
			end
		endfunction

		function logic [31:0] sdiv(logic [31:0] n, logic [31:0] d);
			logic [31:0] na, da, q;
			if (d == 0) begin
				f_div0 = 1;
				return 0;
			end
			na = n[31] ? -n : n;
			da = d[31] ? -d : d;
			q = na / da;
			return (n[31] != d[31]) ? -q : q;
		endfunction

		// note one accepted input transaction
		function void note_input(pee_in_t t);
			logic [31:0] a, b, r;
			pee_out_t o;
			if (t.char_code >= CH_ZERO && t.char_code <= CH_NINE) begin
				acc = acc * 10 + 32'(t.char_code - CH_ZERO);
				pending = 1;
			end else if (t.char_code == CH_SPACE) begin
				if (pending) begin
					push_val(acc);
					acc = 0;
					pending = 0;
				end
			end else if (t.char_code == CH_PLUS || t.char_code == CH_MINUS ||
					t.char_code == CH_STAR || t.char_code == CH_SLASH) begin
				a = top_val(); pop_one();
				b = top_val(); pop_one();
				case (t.char_code)
					CH_PLUS: r = b + a;
					CH_MINUS: r = b - a;
					CH_STAR: r = b * a;
					default: r = sdiv(b, a);
				endcase
				push_val(r);
			end
			if (t.last) begin
				o.answer = top_val();
				o.final_depth = 8'(depth);
				o.underflow_seen = f_under;
				o.overflow_seen = f_over;
				o.divide_by_zero_seen = f_div0;
				answers_due.push_back(o);
				clear();
			end
		endfunction

		// compare one accepted result transaction
		function void check_result(pee_out_t got);
			pee_out_t e;
			checked++;
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			e = answers_due.pop_front();
			if (got.answer !== e.answer || got.final_depth !== e.final_depth ||
					got.underflow_seen !== e.underflow_seen ||
					got.overflow_seen !== e.overflow_seen ||
					got.divide_by_zero_seen !== e.divide_by_zero_seen) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", e, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_we;
	pee_in_t in_data;
	pee_out_t out_data;
	logic [7:0] cfg_wdata;
	rpn_scoreboard sb;
	int idle_cycles = 0;
	int sent;
	bit hold_off = 0;

	postfix_expression_evaluator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// send one character transaction; valid stays up until a gap or a drain
	task automatic send_char(logic [7:0] c, bit lst);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{char_code: c, last: lst};
		do @(posedge clk); while (in_stall);
		sb.note_input('{char_code: c, last: lst});
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	// wait for every due answer, then let the block drain
	task automatic settle();
		in_valid <= 0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_limit(logic [7:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.limit = v;
	endtask

	// random expression of numbers and operators, not always well-formed, with occasional noise
	task automatic send_random_expr(int maxlen);
		int n, ops;
		logic [7:0] c;
		n = $urandom_range(1, maxlen);
		ops = 0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 14 : 3))
						send_char(CH_ZERO + 8'($urandom_range(0, 9)), 0);
					send_char(CH_SPACE, 0);
				end
				4, 5, 6: begin
					case ($urandom_range(0, 3))
						0: c = CH_PLUS;
						1: c = CH_MINUS;
						2: c = CH_STAR;
						default: c = CH_SLASH;
					endcase
					send_char(c, 0);
				end
				7: send_char(8'($urandom_range(0, 255)), 0);
				8: send_char(CH_SPACE, 0);
				default: send_char(CH_ZERO + 8'($urandom_range(0, 9)), 0);
			endcase
		end
		case ($urandom_range(0, 3))
			0: c = CH_PLUS;
			1: c = CH_SPACE;
			2: c = CH_SLASH;
			default: c = 8'($urandom_range(0, 255));
		endcase
		send_char(c, 1);
	endtask

	// receiver: random stall with one long hold-off
	initial begin
		int g;
		bit held;
		held = 0;
		out_stall <= 1;
		@(posedge arst_n);
		forever begin
			if (hold_off && !held) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				held = 1;
			end
			g = gap_len();
			if (g > 0) begin
				out_stall <= 1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(out_data);
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("watchdog: no transaction for 5000 cycles");
				$display("postfix_expression_evaluator test failed");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		sent = 0;
		in_valid <= 0;
		in_data <= '0;
		cfg_we <= 0;
		cfg_wdata <= 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: arithmetic, wrap, empty stack, zero divisor, skipped chars
		send_text("3 4 +");
		send_text("10 3 -");
		send_text("65536 65536 *");
		send_text("7 2 /");
		send_text("7 0 /");
		send_text("2147483648 4294967295 /");
		send_text("99999999999 ");
		send_text("+");
		send_text("  5 % 6 ");
		send_text("12a3 4x  -");
		send_text("1 2");
		send_char(8'hFF, 1);
		send_char(8'h00, 1);
		settle();
		set_limit(8'd1);
		send_text("1 2 3 ");
		settle();
		set_limit(8'd0);
		send_text("5 ");
		settle();
		set_limit(8'd255);
		send_text("1 1 1 1 + + +");
		settle();

		// random phases across limits, one with a long receiver hold-off
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_limit(8'd128);
				1: set_limit(8'd2);
				2: set_limit(8'd1);
				3: set_limit(8'($urandom_range(3, 20)));
				4: set_limit(8'd100);
				default: set_limit(8'($urandom_range(0, 255)));
			endcase
			if (ph == 2) hold_off = 1;
			while (sent < 230 * (ph + 1)) send_random_expr(ph == 0 ? 40 : 10);
			settle();
		end
		// a long run that fills a deep stack
		set_limit(8'd128);
		for (int i = 0; i < 130; i++) send_char(CH_ZERO + 8'(i % 10), 0);
		repeat (130) begin
			send_char(CH_ZERO + 8'($urandom_range(0, 9)), 0);
			send_char(CH_SPACE, 0);
		end
		send_char(CH_STAR, 1);
		settle();

		$display("covered %0d characters, %0d answers, limits 0 to 255", sent, sb.checked);
		$display("including empty, full, zero-divisor and wrap cases");
		if (sb.mismatches == 0 && sb.answers_due.size() == 0)
			$display("postfix_expression_evaluator test passed");
		else
			$display("postfix_expression_evaluator test failed");
		$finish;
	end
endmodule
